### rtl/nfba_pkg.sv
package nfba_pkg;

  // default table depth
  localparam int MAX_BLOCKS = 16;

  // field widths
  localparam int JOB_W  = 16;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 4;

  // input action codes
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_REQUEST = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CHK,
    S_LD_PUT,
    S_RQ_RD,
    S_RQ_CHK,
    S_RES
  } state_e;

  // one table entry as stored in the ram
  typedef struct packed {
    logic              used;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] location;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result word
  typedef struct packed {
    status_e           status;
    logic [JOB_W-1:0]  job;
    logic [DATA_W-1:0] location;
    logic [DATA_W-1:0] size;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

### rtl/nfba_ram.sv
module nfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/nfba_ctrl.sv
module nfba_ctrl #(
  parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [nfba_pkg::JOB_W-1:0]   job_id_i,
  input  logic [nfba_pkg::DATA_W-1:0]  request_size_i,
  input  logic [nfba_pkg::DATA_W-1:0]  block_location_i,
  input  logic [nfba_pkg::DATA_W-1:0]  block_size_i,
  output logic                         res_valid_o,
  input  logic                         res_take_i,
  output nfba_pkg::result_t            res_o
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  nfba_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     start_q, start_d;
  logic [AW-1:0]     put_q, put_d;
  logic [nfba_pkg::DATA_W-1:0] need_q, need_d;
  logic [nfba_pkg::DATA_W-1:0] new_loc_q, new_loc_d;
  logic [nfba_pkg::DATA_W-1:0] new_size_q, new_size_d;
  nfba_pkg::result_t res_q, res_d;

  // ram port
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  nfba_pkg::entry_t             wr_entry;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [nfba_pkg::ENTRY_W-1:0] rd_data;
  nfba_pkg::entry_t             rd_entry;

  // scan helpers
  logic [AW-1:0] idx_inc;
  logic [CW-1:0] idx_inc_wide;
  logic [AW-1:0] scan_next;

  assign rd_entry     = nfba_pkg::entry_t'(rd_data);
  assign idx_inc      = idx_q + AW'(1);
  assign idx_inc_wide = CW'(idx_q) + CW'(1);
  assign scan_next    = (idx_inc_wide >= count_q) ? '0 : idx_inc;

  nfba_ram #(
    .WIDTH (nfba_pkg::ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfba_pkg::S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    start_q    <= start_d;
    put_q      <= put_d;
    need_q     <= need_d;
    new_loc_q  <= new_loc_d;
    new_size_q <= new_size_d;
    res_q      <= res_d;
  end

  // next state, table access and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    idx_d      = idx_q;
    start_d    = start_q;
    put_d      = put_q;
    need_d     = need_q;
    new_loc_d  = new_loc_q;
    new_size_d = new_size_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    wr_addr    = idx_inc;
    wr_entry   = rd_entry;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    in_stall_o = 1'b1;
    res_valid_o = 1'b0;

    case (state_q)
      nfba_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          need_d          = request_size_i;
          new_loc_d       = block_location_i;
          new_size_d      = block_size_i;
          res_d.status    = nfba_pkg::ST_OK;
          res_d.job       = job_id_i;
          res_d.location  = '0;
          res_d.size      = '0;
          res_d.slot      = '0;
          state_d         = nfba_pkg::S_RES;
          case (nfba_pkg::action_e'(action_i))
            nfba_pkg::ACT_CLEAR: begin
              count_d = '0;
              ptr_d   = '0;
            end
            nfba_pkg::ACT_LOAD: begin
              if (count_q == CW'(MAX_BLOCKS)) begin
                res_d.status = nfba_pkg::ST_FULL;
              end else if (count_q == '0) begin
                // first block goes straight to slot zero
                wr_en             = 1'b1;
                wr_addr           = '0;
                wr_entry.used     = 1'b0;
                wr_entry.size     = block_size_i;
                wr_entry.location = block_location_i;
                count_d           = count_q + CW'(1);
                ptr_d             = '0;
              end else begin
                // shift larger blocks up, starting from the top
                idx_d   = AW'(count_q - CW'(1));
                state_d = nfba_pkg::S_LD_RD;
              end
            end
            nfba_pkg::ACT_REQUEST: begin
              if (count_q == '0) begin
                res_d.status = nfba_pkg::ST_NOFIT;
              end else begin
                start_d = (CW'(ptr_q) >= count_q) ? '0 : ptr_q;
                idx_d   = (CW'(ptr_q) >= count_q) ? '0 : ptr_q;
                state_d = nfba_pkg::S_RQ_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      nfba_pkg::S_LD_RD: begin
        rd_en   = 1'b1;
        state_d = nfba_pkg::S_LD_CHK;
      end

      nfba_pkg::S_LD_CHK: begin
        if (rd_entry.size > new_size_q) begin
          // move entry one slot up, used mark travels along
          wr_en = 1'b1;
          if (idx_q == '0) begin
            put_d   = '0;
            state_d = nfba_pkg::S_LD_PUT;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = nfba_pkg::S_LD_RD;
          end
        end else begin
          put_d   = idx_inc;
          state_d = nfba_pkg::S_LD_PUT;
        end
      end

      nfba_pkg::S_LD_PUT: begin
        wr_en             = 1'b1;
        wr_addr           = put_q;
        wr_entry.used     = 1'b0;
        wr_entry.size     = new_size_q;
        wr_entry.location = new_loc_q;
        count_d           = count_q + CW'(1);
        ptr_d             = '0;
        state_d           = nfba_pkg::S_RES;
      end

      nfba_pkg::S_RQ_RD: begin
        rd_en   = 1'b1;
        state_d = nfba_pkg::S_RQ_CHK;
      end

      nfba_pkg::S_RQ_CHK: begin
        if (!rd_entry.used && (rd_entry.size >= need_q)) begin
          // claim the block and leave the pointer on it
          wr_en          = 1'b1;
          wr_addr        = idx_q;
          wr_entry.used  = 1'b1;
          ptr_d          = idx_q;
          res_d.location = rd_entry.location;
          res_d.size     = rd_entry.size;
          res_d.slot     = nfba_pkg::SLOT_W'(idx_q);
          state_d        = nfba_pkg::S_RES;
        end else if (scan_next == start_q) begin
          ptr_d        = start_q;
          res_d.status = nfba_pkg::ST_NOFIT;
          state_d      = nfba_pkg::S_RES;
        end else begin
          idx_d   = scan_next;
          state_d = nfba_pkg::S_RQ_RD;
        end
      end

      nfba_pkg::S_RES: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = nfba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = nfba_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

### rtl/next_fit_block_allocator.sv
// Next-fit block allocator over a table of up to MAX_BLOCKS free blocks.
// Input channel: in_valid_i / in_stall_o carry one word with action_i
// (clear, load, request), job_id_i, request_size_i, block_location_i and
// block_size_i. Every accepted word yields exactly one result word on the
// output channel out_valid_o / out_stall_i with status_o, granted_job_o,
// granted_location_o, granted_size_o and granted_slot_o.
// The table lives in one single-port-write ram with a registered read, so
// each table entry visited takes a read step, then a check and write back step.
// Clear, full load, idle action, empty request and first load go straight to
// the result; a load first visits each block it shifts, then writes the new
// block, and a request visits entries until one fits, at most MAX_BLOCKS.
// One word is worked on at a time; in_stall_o is low only while idle.
// The output register holds a finished word while out_stall_i is high, and
// the next word can be accepted and processed meanwhile; its result then waits
// in the controller until the output register frees.
// Reset clears the entry count, the search pointer and the output valid; the
// ram contents need no clearing since only entries below the count are read.
module next_fit_block_allocator #(
  parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [nfba_pkg::JOB_W-1:0]   job_id_i,
  input  logic [nfba_pkg::DATA_W-1:0]  request_size_i,
  input  logic [nfba_pkg::DATA_W-1:0]  block_location_i,
  input  logic [nfba_pkg::DATA_W-1:0]  block_size_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [nfba_pkg::JOB_W-1:0]   granted_job_o,
  output logic [nfba_pkg::DATA_W-1:0]  granted_location_o,
  output logic [nfba_pkg::DATA_W-1:0]  granted_size_o,
  output logic [nfba_pkg::SLOT_W-1:0]  granted_slot_o
);

  logic              res_valid;
  logic              res_take;
  nfba_pkg::result_t res;
  logic              out_valid_q, out_valid_d;
  nfba_pkg::result_t out_q, out_d;

  nfba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .job_id_i         (job_id_i),
    .request_size_i   (request_size_i),
    .block_location_i (block_location_i),
    .block_size_i     (block_size_i),
    .res_valid_o      (res_valid),
    .res_take_i       (res_take),
    .res_o            (res)
  );

  // output register loads when empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign granted_job_o      = out_q.job;
  assign granted_location_o = out_q.location;
  assign granted_size_o     = out_q.size;
  assign granted_slot_o     = out_q.slot;

endmodule
